[rtl/tcgr_pkg.sv]
// Shared types and constants for the text console glyph renderer.
package tcgr_pkg;

  localparam int unsigned FONT_AW      = 11;
  localparam int unsigned FONT_DEPTH   = 2048;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam logic [7:0]  NEWLINE_CODE = 8'd10;
  localparam logic [2:0]  BYTES_PER_PX = 3'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OPAQUE_MODE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLUMNS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_ROWS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE   = 3'd6;

  // Input opcodes
  localparam logic OP_LOAD_FONT = 1'b0;
  localparam logic OP_PUT_CHAR  = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  char_code;
    logic [10:0] font_index;
    logic [7:0]  font_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel_address;
    logic [23:0] pixel_color;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [23:0] fg_color;
    logic [23:0] bg_color;
    logic        opaque_mode;
    logic [7:0]  text_columns;
    logic [6:0]  text_rows;
    logic [15:0] line_pitch;
    logic [31:0] frame_base;
  } cfg_regs_t;

  // Font store request: one access per cycle, read or write
  typedef struct packed {
    logic             wr_en;
    logic             rd_en;
    logic [FONT_AW-1:0] addr;
    logic [7:0]       wr_data;
  } font_req_t;

endpackage

[rtl/tcgr_font_mem.sv]
// Font store: 2048 x 8 single-port synchronous memory with registered read data.
module tcgr_font_mem (
  input  logic                clk,
  input  tcgr_pkg::font_req_t req,
  output logic [7:0]          rd_data
);

  logic [7:0] mem [tcgr_pkg::FONT_DEPTH];
  logic [7:0] rd_data_r;

  // Write port and registered read; read data holds until the next read
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/tcgr_draw.sv]
// Cursor handling, glyph scan sequencer, pixel address generation and output stage.
module tcgr_draw (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tcgr_pkg::cfg_regs_t  cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tcgr_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tcgr_pkg::out_item_t  out_data,
  output tcgr_pkg::font_req_t  font_req,
  input  logic [7:0]           font_rd_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_BASE,
    S_PIX,
    S_FLUSH
  } state_t;

  state_t              state_r, state_nxt;
  logic [2:0]          x_r, x_nxt;
  logic [2:0]          y_r, y_nxt;
  logic [7:0]          code_r, code_nxt;
  logic [7:0]          col_r, col_nxt;
  logic [6:0]          row_r, row_nxt;
  logic [7:0]          dcol_r, dcol_nxt;
  logic [6:0]          drow_r, drow_nxt;
  logic [25:0]         prod_r, prod_nxt;
  logic [12:0]         col24_r, col24_nxt;
  logic [31:0]         line_r, line_nxt;
  logic [31:0]         pix_r, pix_nxt;
  logic                pend_v_r, pend_v_nxt;
  logic [31:0]         pend_addr_r, pend_addr_nxt;
  logic [23:0]         pend_color_r, pend_color_nxt;
  logic                out_valid_r, out_valid_nxt;
  tcgr_pkg::out_item_t out_data_r, out_data_nxt;

  logic       in_xfer;
  logic       adv;
  logic       bit_set;
  logic       emit;
  logic [7:0] row_inc;
  logic [6:0] row_adv;
  logic       wrap;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Pending pixel can step forward when the output slot frees up
  assign adv = !pend_v_r || !out_valid_r || out_ready;

  assign bit_set = font_rd_data[3'd7 - x_r];
  assign emit    = bit_set || cfg.opaque_mode;

  // Row advance with wrap to the top
  assign row_inc = {1'b0, row_r} + 8'd1;
  assign row_adv = (row_inc >= {1'b0, cfg.text_rows}) ? 7'd0 : row_inc[6:0];
  assign wrap    = (col_r >= cfg.text_columns);

  // Font store access: writes on font load, reads at glyph start and row ends
  always_comb begin
    font_req         = '0;
    font_req.wr_data = in_data.font_byte;
    priority if (in_xfer && in_data.opcode == tcgr_pkg::OP_LOAD_FONT) begin
      font_req.wr_en = 1'b1;
      font_req.addr  = in_data.font_index;
    end else if (state_r == S_MUL) begin
      font_req.rd_en = 1'b1;
      font_req.addr  = {code_r, 3'd0};
    end else if (state_r == S_PIX && adv && x_r == 3'd7 && y_r != 3'd7) begin
      font_req.rd_en = 1'b1;
      font_req.addr  = {code_r, y_r + 3'd1};
    end else begin
      font_req.addr  = {code_r, y_r};
    end
  end

  // Next-state logic
  always_comb begin
    state_nxt      = state_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    code_nxt       = code_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    dcol_nxt       = dcol_r;
    drow_nxt       = drow_r;
    prod_nxt       = prod_r;
    col24_nxt      = col24_r;
    line_nxt       = line_r;
    pix_nxt        = pix_r;
    pend_v_nxt     = pend_v_r;
    pend_addr_nxt  = pend_addr_r;
    pend_color_nxt = pend_color_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && in_data.opcode == tcgr_pkg::OP_PUT_CHAR) begin
          if (in_data.char_code == tcgr_pkg::NEWLINE_CODE) begin
            col_nxt = 8'd0;
            row_nxt = row_adv;
          end else begin
            dcol_nxt  = wrap ? 8'd0 : col_r;
            drow_nxt  = wrap ? row_adv : row_r;
            col_nxt   = (wrap ? 8'd0 : col_r) + 8'd1;
            row_nxt   = wrap ? row_adv : row_r;
            code_nxt  = in_data.char_code;
            x_nxt     = 3'd0;
            y_nxt     = 3'd0;
            state_nxt = S_MUL;
          end
        end
      end
      // Scan-line offset of the text row and byte offset of the column
      S_MUL: begin
        prod_nxt  = {drow_r, 3'd0} * cfg.line_pitch;
        col24_nxt = {1'b0, dcol_r, 4'd0} + {2'b0, dcol_r, 3'd0};
        state_nxt = S_BASE;
      end
      S_BASE: begin
        line_nxt  = cfg.frame_base + {6'd0, prod_r} + {19'd0, col24_r};
        pix_nxt   = cfg.frame_base + {6'd0, prod_r} + {19'd0, col24_r};
        state_nxt = S_PIX;
      end
      // One glyph bit per step, 8 bits per row, 8 rows
      S_PIX: begin
        if (adv) begin
          if (emit) begin
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{pixel_address: pend_addr_r,
                                pixel_color:   pend_color_r,
                                last:          1'b0};
            end
            pend_v_nxt     = 1'b1;
            pend_addr_nxt  = pix_r;
            pend_color_nxt = bit_set ? cfg.fg_color : cfg.bg_color;
          end
          if (x_r == 3'd7) begin
            x_nxt = 3'd0;
            if (y_r == 3'd7) begin
              state_nxt = S_FLUSH;
            end else begin
              y_nxt    = y_r + 3'd1;
              line_nxt = line_r + {16'd0, cfg.line_pitch};
              pix_nxt  = line_r + {16'd0, cfg.line_pitch};
            end
          end else begin
            x_nxt   = x_r + 3'd1;
            pix_nxt = pix_r + {29'd0, tcgr_pkg::BYTES_PER_PX};
          end
        end
      end
      // Final pending pixel goes out marked last; empty glyph emits nothing
      S_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (adv) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{pixel_address: pend_addr_r,
                            pixel_color:   pend_color_r,
                            last:          1'b1};
          pend_v_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      x_r         <= 3'd0;
      y_r         <= 3'd0;
      col_r       <= 8'd0;
      row_r       <= 7'd0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    code_r       <= code_nxt;
    dcol_r       <= dcol_nxt;
    drow_r       <= drow_nxt;
    prod_r       <= prod_nxt;
    col24_r      <= col24_nxt;
    line_r       <= line_nxt;
    pix_r        <= pix_nxt;
    pend_addr_r  <= pend_addr_nxt;
    pend_color_r <= pend_color_nxt;
    out_data_r   <= out_data_nxt;
  end

`ifndef SYNTHESIS
  // No pixel left pending once the character is finished
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_v_r)
    else $error("pending pixel left while idle");

  // The font store never sees a read and a write together
  a_font_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(font_req.wr_en && font_req.rd_en))
    else $error("font store read and write in one cycle");

  // A drawable character closes the input side
  a_char_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_data.opcode == tcgr_pkg::OP_PUT_CHAR &&
     in_data.char_code != tcgr_pkg::NEWLINE_CODE) |=> !in_ready)
    else $error("input accepted during glyph expansion");

  // Flushing the final pixel presents it marked last and returns to idle
  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FLUSH && pend_v_r && adv) |=>
      (state_r == S_IDLE && out_valid_r && out_data_r.last))
    else $error("final pixel not marked last");

  // Bit counter only moves during the pixel scan
  a_x_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_PIX) |-> (x_r == 3'd0))
    else $error("bit counter out of step");
`endif

endmodule

[rtl/text_console_glyph_renderer.sv]
// Top level: configuration registers, font store and glyph drawing sequencer.
// Font loads and newlines are accepted in idle and leave the input ready for the next item.
// A character runs through the row multiply and base add setup states, the scan of its 64 glyph
// bits and a flush state; the bit scan holds while the output is stalled.
// The first pixel transfer follows the first two drawn glyph bits at the earliest, later when
// leading bits are skipped or the output stalls. Reset (rst_n low, synchronous) clears cursor,
// handshake state and restores register defaults; the font store is undefined until loaded.
module text_console_glyph_renderer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  tcgr_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output tcgr_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tcgr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tcgr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  tcgr_pkg::cfg_regs_t cfg_r;
  tcgr_pkg::font_req_t font_req;
  logic [7:0]          font_rd_data;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fg_color     <= 24'hFFFFFF;
      cfg_r.bg_color     <= 24'h000000;
      cfg_r.opaque_mode  <= 1'b0;
      cfg_r.text_columns <= 8'd80;
      cfg_r.text_rows    <= 7'd60;
      cfg_r.line_pitch   <= 16'd1920;
      cfg_r.frame_base   <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tcgr_pkg::REG_FG_COLOR:     cfg_r.fg_color     <= cfg_data[23:0];
        tcgr_pkg::REG_BG_COLOR:     cfg_r.bg_color     <= cfg_data[23:0];
        tcgr_pkg::REG_OPAQUE_MODE:  cfg_r.opaque_mode  <= cfg_data[0];
        tcgr_pkg::REG_TEXT_COLUMNS: cfg_r.text_columns <= cfg_data[7:0];
        tcgr_pkg::REG_TEXT_ROWS:    cfg_r.text_rows    <= cfg_data[6:0];
        tcgr_pkg::REG_LINE_PITCH:   cfg_r.line_pitch   <= cfg_data[15:0];
        tcgr_pkg::REG_FRAME_BASE:   cfg_r.frame_base   <= cfg_data;
        default: ;
      endcase
    end
  end

  tcgr_font_mem u_font_mem (
    .clk     (clk),
    .req     (font_req),
    .rd_data (font_rd_data)
  );

  tcgr_draw u_draw (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .font_req     (font_req),
    .font_rd_data (font_rd_data)
  );

endmodule

[tb/sv/tb.sv]
// Testbench for the text console glyph renderer: font loads, cursor handling and pixel writes.
`timescale 1ns / 100ps

module tb;

  localparam int GLYPH_H       = 8;
  localparam int GLYPH_W       = 8;
  localparam int SETTLE_CYCLES = 100;   // one full character plus margin
  localparam int QUIET_LIMIT   = 5000;  // cycles with no transfer on any channel
  localparam logic [tcgr_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  tcgr_pkg::in_item_t              in_data;
  logic                            out_valid;
  logic                            out_ready;
  tcgr_pkg::out_item_t             out_data;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [tcgr_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [tcgr_pkg::CFG_DATA_W-1:0] cfg_data;

  // Predictor state
  tcgr_pkg::cfg_regs_t shadow_cfg;
  logic [7:0]          pred_column;
  logic [6:0]          pred_row;
  logic [7:0]          pred_font [tcgr_pkg::FONT_DEPTH];
  tcgr_pkg::out_item_t pixel_writes_due [$];

  // Stimulus bookkeeping
  bit          glyph_usable [256];
  logic [7:0]  usable_codes [$];
  int          src_idle_pct;
  int          sink_stall_pct;
  int          mismatches;
  int          quiet_cycles;

  text_console_glyph_renderer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // Row advance with wrap to the top
  function automatic void step_row();
    logic [7:0] nxt;
    nxt = {1'b0, pred_row} + 8'd1;
    if (nxt >= {1'b0, shadow_cfg.text_rows}) pred_row = '0;
    else pred_row = nxt[6:0];
  endfunction

  // Expected pixel writes for one accepted input transfer
  function automatic void render_transfer(input tcgr_pkg::in_item_t item);
    logic [7:0]          bits;
    logic [31:0]         line_off;
    bit                  lit;
    tcgr_pkg::out_item_t px;
    tcgr_pkg::out_item_t glyph_px [$];
    if (item.opcode == tcgr_pkg::OP_LOAD_FONT) begin
      pred_font[item.font_index] = item.font_byte;
      return;
    end
    if (item.char_code == tcgr_pkg::NEWLINE_CODE) begin
      pred_column = '0;
      step_row();
      return;
    end
    if (pred_column >= shadow_cfg.text_columns) begin
      pred_column = '0;
      step_row();
    end
    for (int y = 0; y < GLYPH_H; y++) begin
      bits = pred_font[{item.char_code, y[2:0]}];
      line_off = (32'(pred_row) * GLYPH_H + 32'(y)) * 32'(shadow_cfg.line_pitch);
      for (int x = 0; x < GLYPH_W; x++) begin
        lit = bits[7 - x];
        if (lit || shadow_cfg.opaque_mode) begin
          px.pixel_address = shadow_cfg.frame_base + line_off
                           + (32'(pred_column) * GLYPH_W + 32'(x))
                             * 32'(tcgr_pkg::BYTES_PER_PX);
          px.pixel_color   = lit ? shadow_cfg.fg_color : shadow_cfg.bg_color;
          px.last          = 1'b0;
          glyph_px.push_back(px);
        end
      end
    end
    if (glyph_px.size() > 0) begin
      px = glyph_px.pop_back();
      px.last = 1'b1;
      glyph_px.push_back(px);
    end
    pixel_writes_due = {pixel_writes_due, glyph_px};
    pred_column = pred_column + 8'd1;
  endfunction

  // Transfer monitor: register shadow, prediction and result checking
  always @(posedge clk) begin
    tcgr_pkg::out_item_t due;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tcgr_pkg::REG_FG_COLOR:     shadow_cfg.fg_color     = cfg_data[23:0];
          tcgr_pkg::REG_BG_COLOR:     shadow_cfg.bg_color     = cfg_data[23:0];
          tcgr_pkg::REG_OPAQUE_MODE:  shadow_cfg.opaque_mode  = cfg_data[0];
          tcgr_pkg::REG_TEXT_COLUMNS: shadow_cfg.text_columns = cfg_data[7:0];
          tcgr_pkg::REG_TEXT_ROWS:    shadow_cfg.text_rows    = cfg_data[6:0];
          tcgr_pkg::REG_LINE_PITCH:   shadow_cfg.line_pitch   = cfg_data[15:0];
          tcgr_pkg::REG_FRAME_BASE:   shadow_cfg.frame_base   = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) render_transfer(in_data);
      if (out_valid && out_ready) begin
        if (pixel_writes_due.size() == 0) begin
          report_mismatch($sformatf("unexpected pixel write addr %h color %h",
                                    out_data.pixel_address, out_data.pixel_color));
        end else begin
          due = pixel_writes_due.pop_front();
          if (out_data.pixel_address !== due.pixel_address)
            report_mismatch($sformatf("pixel_address %h, expected %h",
                                      out_data.pixel_address, due.pixel_address));
          if (out_data.pixel_color !== due.pixel_color)
            report_mismatch($sformatf("pixel_color %h, expected %h at addr %h",
                                      out_data.pixel_color, due.pixel_color,
                                      due.pixel_address));
          if (out_data.last !== due.last)
            report_mismatch($sformatf("last %b, expected %b at addr %h",
                                      out_data.last, due.last, due.pixel_address));
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // One input transfer, with random sender gaps before it
  task automatic send_item(input tcgr_pkg::in_item_t item);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Hold off the sender until every expected pixel write has arrived
  task automatic wait_for_results(input bit settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pixel_writes_due.size() != 0) @(posedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [tcgr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] value, input int width);
    logic [31:0] keep;
    keep = (width >= 32) ? '1 : ((32'd1 << width) - 32'd1);
    cfg_index <= idx;
    cfg_data  <= (value & keep) | ($urandom() & ~keep);
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_config(input tcgr_pkg::cfg_regs_t c);
    wait_for_results(1'b1);
    write_reg(tcgr_pkg::REG_FG_COLOR,     32'(c.fg_color),     24);
    write_reg(tcgr_pkg::REG_BG_COLOR,     32'(c.bg_color),     24);
    write_reg(tcgr_pkg::REG_OPAQUE_MODE,  32'(c.opaque_mode),  1);
    write_reg(tcgr_pkg::REG_TEXT_COLUMNS, 32'(c.text_columns), 8);
    write_reg(tcgr_pkg::REG_TEXT_ROWS,    32'(c.text_rows),    7);
    write_reg(tcgr_pkg::REG_LINE_PITCH,   32'(c.line_pitch),   16);
    write_reg(tcgr_pkg::REG_FRAME_BASE,   c.frame_base,        32);
  endtask

  task automatic load_font_byte(input logic [10:0] index, input logic [7:0] value);
    tcgr_pkg::in_item_t item;
    item.opcode     = tcgr_pkg::OP_LOAD_FONT;
    item.char_code  = 8'($urandom());
    item.font_index = index;
    item.font_byte  = value;
    send_item(item);
  endtask

  // Eight rows of one glyph, top row in the upper byte
  task automatic load_glyph(input logic [7:0] code, input logic [63:0] rows);
    for (int y = 0; y < GLYPH_H; y++) begin
      load_font_byte({code, y[2:0]}, rows[63 - 8 * y -: 8]);
    end
    if (!glyph_usable[code]) begin
      glyph_usable[code] = 1'b1;
      usable_codes.push_back(code);
    end
  endtask

  task automatic put_char(input logic [7:0] code);
    tcgr_pkg::in_item_t item;
    item.opcode     = tcgr_pkg::OP_PUT_CHAR;
    item.char_code  = code;
    item.font_index = 11'($urandom());
    item.font_byte  = 8'($urandom());
    send_item(item);
  endtask

  function automatic logic [63:0] random_glyph();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Directed: glyphs at both ends of the font store plus an empty one
  task automatic test_font_loads();
    load_glyph(8'd0,   64'h8001_FF00_A55A_817E);
    load_glyph(8'd255, '1);
    load_glyph(8'd32,  '0);
  endtask

  // Directed: drawing with reset register values, newline, empty transparent glyph
  task automatic test_default_drawing();
    put_char(8'd0);
    put_char(8'd255);
    put_char(8'd32);
    put_char(tcgr_pkg::NEWLINE_CODE);
    put_char(8'd0);
  endtask

  // Directed: opaque mode, largest bounds and pitch, address wrap at 32 bits
  task automatic test_opaque_extremes();
    tcgr_pkg::cfg_regs_t c;
    c = '{fg_color: 24'h000000, bg_color: 24'hFFFFFF, opaque_mode: 1'b1,
          text_columns: 8'd255, text_rows: 7'd127, line_pitch: 16'hFFFF,
          frame_base: 32'hFFFF_FF00};
    apply_config(c);
    put_char(8'd32);
    put_char(8'd255);
    put_char(8'd0);
    wait_for_results(1'b1);
    write_reg(REG_UNUSED, $urandom(), 32);
  endtask

  // Directed: column and row wrap, zero bounds, cursor beyond shrunken bounds
  task automatic test_cursor_wrapping();
    tcgr_pkg::cfg_regs_t c;
    c = '{fg_color: 24'h123456, bg_color: 24'h654321, opaque_mode: 1'b0,
          text_columns: 8'd1, text_rows: 7'd2, line_pitch: 16'd100, frame_base: 32'h1000};
    apply_config(c);
    repeat (3) put_char(8'd0);
    c.text_columns = 8'd0;
    c.text_rows    = 7'd0;
    apply_config(c);
    put_char(8'd0);
    put_char(tcgr_pkg::NEWLINE_CODE);
    put_char(8'd0);
    c.text_columns = 8'd255;
    c.text_rows    = 7'd127;
    apply_config(c);
    repeat (3) put_char(tcgr_pkg::NEWLINE_CODE);
    repeat (3) put_char(8'd0);
    // row now past the new bound, column still inside
    c.text_rows = 7'd2;
    apply_config(c);
    put_char(8'd0);
    c.text_columns = 8'd2;
    apply_config(c);
    put_char(8'd0);
    put_char(tcgr_pkg::NEWLINE_CODE);
  endtask

  task automatic randomise_config();
    tcgr_pkg::cfg_regs_t c;
    c.fg_color    = 24'($urandom());
    c.bg_color    = 24'($urandom());
    c.opaque_mode = 1'($urandom_range(1));
    case ($urandom_range(5))
      0: c.text_columns = 8'd0;
      1: c.text_columns = 8'd255;
      default: c.text_columns = 8'($urandom_range(1, 12));
    endcase
    case ($urandom_range(5))
      0: c.text_rows = 7'd0;
      1: c.text_rows = 7'd127;
      default: c.text_rows = 7'($urandom_range(1, 6));
    endcase
    case ($urandom_range(3))
      0: c.line_pitch = 16'd0;
      1: c.line_pitch = 16'hFFFF;
      default: c.line_pitch = 16'($urandom());
    endcase
    case ($urandom_range(3))
      0: c.frame_base = 32'd0;
      1: c.frame_base = 32'hFFFF_FFFF;
      default: c.frame_base = $urandom();
    endcase
    apply_config(c);
  endtask

  // Random traffic: mostly glyph loads followed by characters, some newlines and stray loads
  task automatic test_random_traffic(input int src_pct, input int sink_pct, input int n_items);
    int         sent;
    int         roll;
    logic [7:0] code;
    randomise_config();
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    sent = 0;
    while (sent < n_items) begin
      roll = $urandom_range(99);
      if (roll < 2) begin
        wait_for_results(1'b0);
      end else if (roll < 10) begin
        load_font_byte(11'($urandom()), 8'($urandom()));
        sent++;
      end else if (roll < 18) begin
        put_char(tcgr_pkg::NEWLINE_CODE);
        sent++;
      end else begin
        if (usable_codes.size() == 0 || roll < 30) begin
          code = 8'($urandom());
          load_glyph(code, random_glyph());
          sent += GLYPH_H;
        end else begin
          code = usable_codes[$urandom_range(usable_codes.size() - 1)];
        end
        put_char(code);
        sent++;
      end
    end
    src_idle_pct   = 0;
    sink_stall_pct = 0;
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    mismatches     = 0;
    quiet_cycles   = 0;
    shadow_cfg     = '{fg_color: 24'hFFFFFF, bg_color: 24'h000000, opaque_mode: 1'b0,
                       text_columns: 8'd80, text_rows: 7'd60, line_pitch: 16'd1920,
                       frame_base: 32'd0};
    pred_column    = '0;
    pred_row       = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_font_loads();
    test_default_drawing();
    test_opaque_extremes();
    test_cursor_wrapping();
    test_random_traffic(0,  0,  75);
    test_random_traffic(64, 0,  75);
    test_random_traffic(0,  64, 75);
    test_random_traffic(17, 17, 75);

    wait_for_results(1'b1);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
